// ===== rtl/lsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants and types for the LPC to LSP Chebyshev root search block.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Frame geometry
  localparam int MAX_ORDER = 16;
  localparam int COEF_W    = 32;
  localparam int ORD_CAP   = MAX_ORDER / 2 * 2;
  localparam int HALF_CAP  = MAX_ORDER / 2;
  localparam int POLY_W    = COEF_W + 8;
  localparam int VAL_W     = COEF_W + 16;
  localparam int X_W       = 32;
  localparam int RAM_DEPTH = 2 * MAX_ORDER;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Multiplier operand and result widths
  localparam int MUL_W  = 48;
  localparam int PROD_W = 51;

  // Configuration register indexes
  localparam logic [1:0] CFG_LPC_ORDER = 2'd0;
  localparam logic [1:0] CFG_GRID_STEP = 2'd1;
  localparam logic [1:0] CFG_BISECT    = 2'd2;

  // Fixed point constants
  localparam logic signed [X_W-1:0] NEG_ONE_Q30 = -32'sd1073741824;

  typedef struct packed {
    logic [4:0]  lpc_order;
    logic [23:0] grid_step;
    logic [3:0]  bisect_steps;
  } cfg_t;

  // One loaded frame waiting for the search engine
  typedef struct packed {
    logic [4:0] order;
    logic [4:0] loaded;
    logic       count_err;
    logic       bank;
  } frame_t;

  typedef struct packed {
    logic                    go;
    logic                    s24;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/lsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/lsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_front
// Coefficient loader: writes coefficients into a two-bank store and queues
// a descriptor for each finished frame (two-entry queue).
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic                     in_last_coef,
  output logic                     wr_en,
  output logic [RAM_AW-1:0]        wr_addr,
  output logic [COEF_W-1:0]        wr_data,
  output logic                     frm_valid,
  output frame_t                   frm,
  input  logic                     frm_pop
);

  logic [4:0] load_cnt_r;
  logic       wr_bank_r;
  frame_t     q_mem_r [2];
  logic       q_wptr_r;
  logic       q_rptr_r;
  logic [1:0] q_cnt_r;

  logic       accept;
  logic       push;
  logic [4:0] cnt_inc;
  logic [4:0] order;
  frame_t     desc;

  // Even order, clamped to the supported range
  function automatic logic [4:0] norm_order(input logic [4:0] v);
    logic [4:0] n;
    n = {v[4:1], 1'b0};
    if (n < 5'd2) n = 5'd2;
    if (n > 5'(ORD_CAP)) n = 5'(ORD_CAP);
    return n;
  endfunction

  assign in_stall  = (q_cnt_r == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign push      = accept && in_last_coef;
  assign frm_valid = (q_cnt_r != 2'd0);
  assign frm       = q_mem_r[q_rptr_r];

  // Store write: entries past the store depth are dropped
  assign wr_en   = accept && (load_cnt_r < 5'(MAX_ORDER));
  assign wr_addr = {wr_bank_r, load_cnt_r[RAM_AW-2:0]};
  assign wr_data = in_coef_value;

  always_comb begin
    cnt_inc        = (load_cnt_r == 5'd31) ? 5'd31 : load_cnt_r + 5'd1;
    order          = norm_order(cfg.lpc_order);
    desc.order     = order;
    desc.loaded    = (cnt_inc > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : cnt_inc;
    desc.count_err = (cnt_inc != order);
    desc.bank      = wr_bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      wr_bank_r  <= 1'b0;
      q_wptr_r   <= 1'b0;
      q_rptr_r   <= 1'b0;
      q_cnt_r    <= '0;
    end else begin
      if (accept) begin
        load_cnt_r <= push ? 5'd0 : cnt_inc;
      end
      if (push) begin
        q_mem_r[q_wptr_r] <= desc;
        q_wptr_r          <= ~q_wptr_r;
        wr_bank_r         <= ~wr_bank_r;
      end
      if (frm_pop) begin
        q_rptr_r <= ~q_rptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, frm_pop};
    end
  end

endmodule

// ===== rtl/lsp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_mul
// Shared signed multiplier with rounding shift (24 or 30 bits), built from
// two 48x24 partial products over successive cycles.
// ----------------------------------------------------------------------------
module lsp_mul import lsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int HB = MUL_W / 2;
  localparam int FW = 2 * MUL_W + 1;
  localparam logic [FW-1:0] LIM = (FW'(1) << (PROD_W - 1)) - FW'(1);

  logic [1:0]        cnt_r;
  logic [MUL_W-1:0]  ua_r;
  logic [MUL_W-1:0]  ub_r;
  logic              neg_r;
  logic              s24_r;
  logic [MUL_W+HB-1:0] pp_lo_r;
  logic [MUL_W+HB-1:0] pp_hi_r;
  logic              done_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [FW-1:0]     full;
  logic [FW-1:0]     rnd;
  logic [FW-1:0]     q;
  logic [PROD_W-2:0] mag;

  // Combine partial products, round half away from zero, clamp
  always_comb begin
    full = {{(FW-MUL_W-HB-HB){1'b0}}, pp_hi_r, {HB{1'b0}}}
         + {{(FW-MUL_W-HB){1'b0}}, pp_lo_r};
    rnd  = full + (s24_r ? (FW'(1) << 23) : (FW'(1) << 29));
    q    = s24_r ? (rnd >> 24) : (rnd >> 30);
    mag  = (q > LIM) ? LIM[PROD_W-2:0] : q[PROD_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (cnt_r)
        2'd0: begin
          if (req.go) begin
            ua_r  <= req.a[MUL_W-1] ? MUL_W'(-req.a) : req.a;
            ub_r  <= req.b[MUL_W-1] ? MUL_W'(-req.b) : req.b;
            neg_r <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
            s24_r <= req.s24;
            cnt_r <= 2'd1;
          end
        end
        2'd1: begin
          pp_lo_r <= ua_r * ub_r[HB-1:0];
          cnt_r   <= 2'd2;
        end
        2'd2: begin
          pp_hi_r <= ua_r * ub_r[MUL_W-1:HB];
          cnt_r   <= 2'd3;
        end
        default: begin
          prod_r <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          done_r <= 1'b1;
          cnt_r  <= 2'd0;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

// ===== rtl/lsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_back
// Search engine: builds P' and Q' from the stored frame, sweeps the grid with
// Chebyshev evaluations, refines each sign change by bisection, emits LSPs.
// ----------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     frm_valid,
  input  frame_t                   frm,
  output logic                     frm_pop,
  output logic [RAM_AW-1:0]        rd_addr_a,
  output logic [RAM_AW-1:0]        rd_addr_b,
  input  logic [COEF_W-1:0]        rd_data_a,
  input  logic [COEF_W-1:0]        rd_data_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [4:0]               out_lsp_index,
  output logic signed [X_W-1:0]    out_lsp_value,
  output logic                     out_root_found,
  output logic [4:0]               out_root_count,
  output logic                     out_count_error,
  output logic                     out_last_lsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_BLD_RD, S_BLD_CALC, S_ROOT, S_GOT_VL, S_STEP_W1, S_STEP_W2,
    S_STEP_W3, S_GOT_VR, S_BIS, S_GOT_VM, S_ROOT_END, S_EV_START, S_EV_A_W,
    S_EV_B_W, S_EV_C_W, S_EMIT
  } state_t;

  localparam logic signed [VAL_W-1:0]  ONE_T   = 48'sd1073741824;
  localparam logic signed [POLY_W-1:0] ONE_P   = 40'sd16777216;
  localparam logic signed [MUL_W-1:0]  NINE_M  = 48'sd966367642;
  localparam logic signed [VAL_W-1:0]  TWO_TEN = 48'sd3355443;
  localparam logic signed [X_W-1:0]    ONE_X   = 32'sd1073741824;

  state_t state_r, ret_r;
  mul_req_t mreq_r;
  mul_rsp_t mrsp;

  logic [4:0] n_r, loaded_r, roots_r, emit_j_r;
  logic [3:0] h_r, i_r, ev_i_r, j_r, k_r;
  logic       err_r, bank_r;
  logic [23:0] delta_r;
  logic signed [POLY_W-1:0] sym_r [HALF_CAP+1];
  logic signed [POLY_W-1:0] asym_r [HALF_CAP+1];
  logic signed [POLY_W-1:0] sprev_r, aprev_r;
  logic signed [X_W-1:0]    lsp_r [MAX_ORDER];
  logic signed [X_W-1:0]    xl_r, xr_r, xm_r, ev_x_r;
  logic signed [VAL_W-1:0]  vl_r, sum_r, t0_r, t1_r;

  logic out_valid_r, out_found_r, out_err_r, out_last_r;
  logic [4:0] out_idx_r, out_cnt_r;
  logic signed [X_W-1:0] out_val_r;

  logic [3:0] cidx;
  logic signed [POLY_W-1:0] coef_c;
  logic signed [COEF_W-1:0] ai, ar;
  logic [5:0] ar_pos;
  logic signed [POLY_W+1:0] s_sum, a_sum, s_dbl, a_dbl;
  logic signed [VAL_W-1:0] sum_a_nxt, sum_c_nxt, t2_nxt;
  logic [30:0] tq, dd;
  logic signed [X_W:0] xr_step, xm_sum;
  logic signed [MUL_W-1:0] x2_m;
  logic emit_go;

  // Saturate to the polynomial value width
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+4:0] v);
    if (v[VAL_W+4:VAL_W-1] == '0 || v[VAL_W+4:VAL_W-1] == '1) return v[VAL_W-1:0];
    return v[VAL_W+4] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // Saturate to the polynomial term width
  function automatic logic signed [POLY_W-1:0] sat_poly(input logic signed [POLY_W+1:0] v);
    if (v[POLY_W+1:POLY_W-1] == '0 || v[POLY_W+1:POLY_W-1] == '1) return v[POLY_W-1:0];
    return v[POLY_W+1] ? {1'b1, {(POLY_W-1){1'b0}}} : {1'b0, {(POLY_W-1){1'b1}}};
  endfunction

  function automatic logic opposite(input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  function automatic logic same_sign(input logic signed [VAL_W-1:0] a,
                                     input logic signed [VAL_W-1:0] b);
    return (a < 0 && b < 0) || (a > 0 && b > 0);
  endfunction

  function automatic logic signed [MUL_W-1:0] sx_x(input logic signed [X_W-1:0] v);
    return {{(MUL_W-X_W){v[X_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_W-1:0] sx_p(input logic signed [POLY_W-1:0] v);
    return {{(MUL_W-POLY_W){v[POLY_W-1]}}, v};
  endfunction

  // Coefficient store addresses for the current build step
  assign rd_addr_a = {bank_r, 4'(i_r - 4'd1)};
  assign rd_addr_b = {bank_r, 4'(n_r - {1'b0, i_r})};

  // Chebyshev coefficient select
  always_comb begin
    case (state_r)
      S_EV_START: cidx = h_r - 4'd1;
      S_EV_B_W:   cidx = h_r - ev_i_r;
      default:    cidx = h_r;
    endcase
    coef_c = j_r[0] ? asym_r[cidx] : sym_r[cidx];
  end

  // Datapath
  always_comb begin
    ai     = ({1'b0, i_r} <= loaded_r) ? $signed(rd_data_a) : '0;
    ar_pos = {1'b0, n_r} + 6'd1 - {2'b0, i_r};
    ar     = (ar_pos <= {1'b0, loaded_r}) ? $signed(rd_data_b) : '0;
    s_sum  = {{10{ai[31]}}, ai} + {{10{ar[31]}}, ar} - {{2{sprev_r[POLY_W-1]}}, sprev_r};
    a_sum  = {{10{ai[31]}}, ai} - {{10{ar[31]}}, ar} + {{2{aprev_r[POLY_W-1]}}, aprev_r};
    s_dbl  = {sprev_r[POLY_W-1], sprev_r, 1'b0};
    a_dbl  = {aprev_r[POLY_W-1], aprev_r, 1'b0};

    sum_a_nxt = sat_val({{5{coef_c[POLY_W-1]}}, {(VAL_W-POLY_W){coef_c[POLY_W-1]}}, coef_c}
                        + {{(VAL_W+5-PROD_W){mrsp.prod[PROD_W-1]}}, mrsp.prod});
    sum_c_nxt = sat_val({{5{sum_r[VAL_W-1]}}, sum_r}
                        + {{(VAL_W+5-PROD_W){mrsp.prod[PROD_W-1]}}, mrsp.prod});
    t2_nxt    = sat_val({{(VAL_W+5-PROD_W){mrsp.prod[PROD_W-1]}}, mrsp.prod}
                        - {{5{t0_r[VAL_W-1]}}, t0_r});

    tq = (mrsp.prod >= PROD_W'(ONE_X)) ? 31'd0 : 31'(ONE_X) - mrsp.prod[30:0];
    dd = (vl_r > -TWO_TEN && vl_r < TWO_TEN) ? {1'b0, mrsp.prod[30:1]} : mrsp.prod[30:0];
    xr_step = {xl_r[X_W-1], xl_r} - $signed({2'b0, dd});
    xm_sum  = ({xl_r[X_W-1], xl_r} + {xr_r[X_W-1], xr_r}) >>> 1;
    x2_m    = {{(MUL_W-X_W-1){ev_x_r[X_W-1]}}, ev_x_r, 1'b0};

    emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  end

  assign frm_pop = emit_go && (emit_j_r == n_r);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      mreq_r.go   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mreq_r.go <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (frm_valid) begin
            n_r      <= frm.order;
            h_r      <= frm.order[4:1];
            loaded_r <= frm.loaded;
            err_r    <= frm.count_err;
            bank_r   <= frm.bank;
            i_r      <= 4'd1;
            sprev_r  <= ONE_P;
            aprev_r  <= ONE_P;
            delta_r  <= (cfg.grid_step == '0) ? 24'd1 : cfg.grid_step;
            state_r  <= S_BLD_RD;
          end
        end
        S_BLD_RD: state_r <= S_BLD_CALC;
        // One polynomial term pair per step; previous term stored doubled
        S_BLD_CALC: begin
          sym_r[i_r - 4'd1]  <= sat_poly(s_dbl);
          asym_r[i_r - 4'd1] <= sat_poly(a_dbl);
          sym_r[i_r]         <= sat_poly(s_sum);
          asym_r[i_r]        <= sat_poly(a_sum);
          sprev_r            <= sat_poly(s_sum);
          aprev_r            <= sat_poly(a_sum);
          if (i_r == h_r) begin
            xl_r    <= ONE_X;
            xr_r    <= '0;
            roots_r <= '0;
            j_r     <= '0;
            state_r <= S_ROOT;
          end else begin
            i_r     <= i_r + 4'd1;
            state_r <= S_BLD_RD;
          end
        end
        S_ROOT: begin
          lsp_r[j_r] <= NEG_ONE_Q30;
          if (xr_r >= NEG_ONE_Q30) begin
            ev_x_r  <= xl_r;
            t0_r    <= ONE_T;
            t1_r    <= {{(VAL_W-X_W){xl_r[X_W-1]}}, xl_r};
            ret_r   <= S_GOT_VL;
            state_r <= S_EV_START;
          end else begin
            state_r <= S_ROOT_END;
          end
        end
        S_GOT_VL: begin
          vl_r       <= sum_r;
          mreq_r.go  <= 1'b1;
          mreq_r.a   <= sx_x(xl_r);
          mreq_r.b   <= sx_x(xl_r);
          mreq_r.s24 <= 1'b0;
          state_r    <= S_STEP_W1;
        end
        S_STEP_W1: begin
          if (mrsp.done) begin
            mreq_r.go  <= 1'b1;
            mreq_r.a   <= NINE_M;
            mreq_r.b   <= MUL_W'(mrsp.prod);
            mreq_r.s24 <= 1'b0;
            state_r    <= S_STEP_W2;
          end
        end
        S_STEP_W2: begin
          if (mrsp.done) begin
            mreq_r.go  <= 1'b1;
            mreq_r.a   <= {24'd0, delta_r};
            mreq_r.b   <= {17'd0, tq};
            mreq_r.s24 <= 1'b1;
            state_r    <= S_STEP_W3;
          end
        end
        S_STEP_W3: begin
          if (mrsp.done) begin
            xr_r    <= xr_step[X_W-1:0];
            ev_x_r  <= xr_step[X_W-1:0];
            t0_r    <= ONE_T;
            t1_r    <= {{(VAL_W-X_W){xr_step[X_W-1]}}, xr_step[X_W-1:0]};
            ret_r   <= S_GOT_VR;
            state_r <= S_EV_START;
          end
        end
        S_GOT_VR: begin
          if (opposite(sum_r, vl_r)) begin
            roots_r <= roots_r + 5'd1;
            k_r     <= '0;
            state_r <= S_BIS;
          end else begin
            vl_r <= sum_r;
            xl_r <= xr_r;
            if (xr_r >= NEG_ONE_Q30) begin
              mreq_r.go  <= 1'b1;
              mreq_r.a   <= sx_x(xr_r);
              mreq_r.b   <= sx_x(xr_r);
              mreq_r.s24 <= 1'b0;
              state_r    <= S_STEP_W1;
            end else begin
              state_r <= S_ROOT_END;
            end
          end
        end
        S_BIS: begin
          xm_r    <= xm_sum[X_W-1:0];
          ev_x_r  <= xm_sum[X_W-1:0];
          t0_r    <= ONE_T;
          t1_r    <= {{(VAL_W-X_W){xm_sum[X_W-1]}}, xm_sum[X_W-1:0]};
          ret_r   <= S_GOT_VM;
          state_r <= S_EV_START;
        end
        S_GOT_VM: begin
          if (same_sign(sum_r, vl_r)) begin
            vl_r <= sum_r;
            xl_r <= xm_r;
          end else begin
            xr_r <= xm_r;
          end
          if (k_r == cfg.bisect_steps) begin
            lsp_r[j_r] <= xm_r;
            xl_r       <= xm_r;
            state_r    <= S_ROOT_END;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_BIS;
          end
        end
        S_ROOT_END: begin
          if ({1'b0, j_r} == n_r - 5'd1) begin
            emit_j_r <= '0;
            state_r  <= S_EMIT;
          end else begin
            j_r     <= j_r + 4'd1;
            state_r <= S_ROOT;
          end
        end
        // Chebyshev recursion: first order term
        S_EV_START: begin
          mreq_r.go  <= 1'b1;
          mreq_r.a   <= sx_p(coef_c);
          mreq_r.b   <= sx_x(ev_x_r);
          mreq_r.s24 <= 1'b0;
          state_r    <= S_EV_A_W;
        end
        S_EV_A_W: begin
          if (mrsp.done) begin
            sum_r <= sum_a_nxt;
            if (h_r == 4'd1) begin
              state_r <= ret_r;
            end else begin
              ev_i_r     <= 4'd2;
              mreq_r.go  <= 1'b1;
              mreq_r.a   <= x2_m;
              mreq_r.b   <= t1_r;
              mreq_r.s24 <= 1'b0;
              state_r    <= S_EV_B_W;
            end
          end
        end
        // Next T_i, then accumulate its term
        S_EV_B_W: begin
          if (mrsp.done) begin
            t0_r       <= t1_r;
            t1_r       <= t2_nxt;
            mreq_r.go  <= 1'b1;
            mreq_r.a   <= sx_p(coef_c);
            mreq_r.b   <= t2_nxt;
            mreq_r.s24 <= 1'b0;
            state_r    <= S_EV_C_W;
          end
        end
        S_EV_C_W: begin
          if (mrsp.done) begin
            sum_r <= sum_c_nxt;
            if (ev_i_r == h_r) begin
              state_r <= ret_r;
            end else begin
              ev_i_r     <= ev_i_r + 4'd1;
              mreq_r.go  <= 1'b1;
              mreq_r.a   <= x2_m;
              mreq_r.b   <= t1_r;
              mreq_r.s24 <= 1'b0;
              state_r    <= S_EV_B_W;
            end
          end
        end
        // Result transactions, one per LSP
        S_EMIT: begin
          if (emit_go) begin
            if (emit_j_r != n_r) begin
              out_valid_r <= 1'b1;
              out_idx_r   <= emit_j_r;
              out_val_r   <= lsp_r[emit_j_r[3:0]];
              out_found_r <= (emit_j_r < roots_r);
              out_cnt_r   <= roots_r;
              out_err_r   <= err_r;
              out_last_r  <= (emit_j_r == n_r - 5'd1);
              emit_j_r    <= emit_j_r + 5'd1;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  lsp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq_r),
    .rsp   (mrsp)
  );

  assign out_valid       = out_valid_r;
  assign out_lsp_index   = out_idx_r;
  assign out_lsp_value   = out_val_r;
  assign out_root_found  = out_found_r;
  assign out_root_count  = out_cnt_r;
  assign out_count_error = out_err_r;
  assign out_last_lsp    = out_last_r;

endmodule

// ===== rtl/lpc_to_lsp_chebyshev_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_to_lsp_chebyshev_search
// LPC to line spectral pair conversion by Chebyshev root search.
// ----------------------------------------------------------------------------
// Coefficients a1..aN arrive one per transaction (Q8.24), the frame closed by
// last_coef; N LSP transactions (Q1.30, x domain) follow per frame. The loader
// takes one coefficient per cycle and buffers up to two whole frames, stalling
// only when both are pending. The search engine works one frame at a time; its
// speed is set by one shared multiplier: each grid step adds three multiplies
// before its evaluation, and each root adds bisection_steps+1 evaluations.
// ----------------------------------------------------------------------------
module lpc_to_lsp_chebyshev_search import lsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic                     in_last_coef,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [4:0]               out_lsp_index,
  output logic signed [X_W-1:0]    out_lsp_value,
  output logic                     out_root_found,
  output logic [4:0]               out_root_count,
  output logic                     out_count_error,
  output logic                     out_last_lsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [23:0]              cfg_data
);

  cfg_t cfg_r;
  logic                wr_en;
  logic [RAM_AW-1:0]   wr_addr, rd_addr_a, rd_addr_b;
  logic [COEF_W-1:0]   wr_data, rd_data_a, rd_data_b;
  logic                frm_valid, frm_pop;
  frame_t              frm;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lpc_order    <= 5'd10;
      cfg_r.grid_step    <= 24'd335544;
      cfg_r.bisect_steps <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LPC_ORDER: cfg_r.lpc_order    <= cfg_data[4:0];
        CFG_GRID_STEP: cfg_r.grid_step    <= cfg_data;
        CFG_BISECT:    cfg_r.bisect_steps <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_coef_value (in_coef_value),
    .in_last_coef  (in_last_coef),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .frm_valid     (frm_valid),
    .frm           (frm),
    .frm_pop       (frm_pop)
  );

  lsp_ram #(.WIDTH(COEF_W), .DEPTH(RAM_DEPTH)) u_coef_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  lsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .frm_valid       (frm_valid),
    .frm             (frm),
    .frm_pop         (frm_pop),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lsp_index   (out_lsp_index),
    .out_lsp_value   (out_lsp_value),
    .out_root_found  (out_root_found),
    .out_root_count  (out_root_count),
    .out_count_error (out_count_error),
    .out_last_lsp    (out_last_lsp)
  );

  // A root that was not found is reported as -1
  a_missing_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_root_found |-> out_lsp_value == NEG_ONE_Q30)
    else $error("missing root not reported as -1");

  // Found roots are the leading ones of the frame
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_found |-> out_lsp_index < out_root_count)
    else $error("found flag beyond root count");

  // LSP indexes advance by one within a frame
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_lsp |=>
      out_valid && out_lsp_index == $past(out_lsp_index) + 5'd1)
    else $error("LSP index did not advance");

  // Nothing follows the last LSP of a frame directly
  a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_lsp |=> !out_valid)
    else $error("result shown right after last LSP");

endmodule
